[src/buddy_pkg.sv]
// ----------------------------------------------------------------------------
// buddy_pkg
// Shared constants and payload types for the binary buddy allocator.
// ----------------------------------------------------------------------------
package buddy_pkg;

  localparam int HEAP_LOG2  = 16;
  localparam int MIN_LOG2   = 4;
  localparam int BUCKETS    = HEAP_LOG2 - MIN_LOG2 + 1;
  localparam int NODE_W     = BUCKETS;
  localparam int SPLIT_W    = BUCKETS - 1;
  localparam int LVL_W      = $clog2(BUCKETS);
  localparam int NEED_W     = 18;
  localparam int OFS_W      = HEAP_LOG2 + 1;
  localparam int HDR_BYTES  = 8;

  localparam logic [NODE_W-1:0] NONE_NODE = {NODE_W{1'b1}};

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic        command;
    logic [16:0] request_size;
    logic [31:0] block_address;
  } cmd_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic        status;
  } res_t;

endpackage

[src/buddy_allocator_core.sv]
// ----------------------------------------------------------------------------
// buddy_allocator_core
// Binary buddy allocator: free lists as linked node links in on-chip RAM,
// split flags in a bit RAM, handled by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
//  channel   | signals                       | direction
//  ----------+-------------------------------+----------
//  command   | in_valid, in_ready, in_data   | in
//  result    | out_valid, out_ready, out_data| out
//  config    | cfg_we, cfg_wdata (heap_base) | in
//
//  One command at a time. Allocate unlinks a free block, then splits it
//  level by level. Free merges level by level until a split flag stops
//  the merge, then pushes the final block onto its free list.
//  Each level costs a RAM read, its registered read data and write-backs.
//  After reset the link and split RAMs are cleared,
//  with in_ready low. A result waiting on out_ready holds the sequencer
//  at its last step, but the next command is taken once the slot moves.
module buddy_allocator_core
  import buddy_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  cmd_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_UL_READ, S_UL_LINK, S_UL_CLR,
    S_TG_READ, S_TG_WRITE, S_A_LOOP, S_F_LOOP, S_PU_W1, S_PU_W2, S_FINISH
  } state_t;

  state_t              state;
  logic [31:0]         heap_base;
  logic                cmd;
  logic [NEED_W-1:0]   need;
  logic [31:0]         addr;
  logic [NODE_W-1:0]   n;
  logic [NODE_W-1:0]   t;
  logic [LVL_W-1:0]    lvl;
  logic [LVL_W-1:0]    want;
  logic                first;
  logic [31:0]         res_addr;
  logic                res_st;
  logic [NODE_W-1:0]   clr_cnt;
  logic [NODE_W-1:0]   list_front [BUCKETS];
  logic [NODE_W-1:0]   list_back  [BUCKETS];

  // link and split RAMs
  logic [NODE_W-1:0]   prev_mem  [2**NODE_W];
  logic [NODE_W-1:0]   next_mem  [2**NODE_W];
  logic                split_mem [2**SPLIT_W];
  logic [NODE_W-1:0]   prev_q, next_q;
  logic                split_q;

  logic                prev_we, next_we, split_we;
  logic [NODE_W-1:0]   prev_wa, next_wa, prev_wd, next_wd;
  logic [SPLIT_W-1:0]  split_wa;
  logic                split_wd;
  logic [SPLIT_W-1:0]  parent_idx;
  logic [NODE_W-1:0]   n_dec;

  // decode helpers
  logic [LVL_W-1:0]    want_c;
  logic [LVL_W-1:0]    sel_c;
  logic                found_c;
  logic [31:0]         off_c;
  logic [NODE_W-1:0]   fnode_c;
  logic [OFS_W-1:0]    ofs_c;
  logic [NODE_W-1:0]   buddy_c;

  assign in_ready   = (state == S_IDLE);
  assign n_dec      = n - NODE_W'(1);
  assign parent_idx = n_dec[NODE_W-1:1];
  assign buddy_c    = ((n - NODE_W'(1)) ^ NODE_W'(1)) + NODE_W'(1);

  // bucket of the request and highest usable non-empty bucket
  always_comb begin
    want_c  = '0;
    sel_c   = '0;
    found_c = 1'b0;
    for (int b = 0; b < BUCKETS; b++) begin
      if ((NEED_W'(1) << (MIN_LOG2 + BUCKETS - 1 - b)) >= need) begin
        want_c = LVL_W'(b);
      end
    end
    for (int b = 0; b < BUCKETS; b++) begin
      if (LVL_W'(b) <= want_c && list_back[b] != NONE_NODE) begin
        sel_c   = LVL_W'(b);
        found_c = 1'b1;
      end
    end
  end

  // block offset of the node being taken, and node of the block being freed
  always_comb begin
    ofs_c   = (OFS_W'(n) - ((OFS_W'(1) << lvl) - OFS_W'(1))) << (HEAP_LOG2 - lvl);
    off_c   = addr - heap_base - 32'(HDR_BYTES);
    fnode_c = NODE_W'(off_c[HEAP_LOG2-1:0] >> (HEAP_LOG2 - want_c))
              + ((NODE_W'(1) << want_c) - NODE_W'(1));
  end

  // RAM write controls
  always_comb begin
    prev_we  = 1'b0;
    next_we  = 1'b0;
    split_we = 1'b0;
    prev_wa  = t;
    next_wa  = t;
    prev_wd  = NONE_NODE;
    next_wd  = NONE_NODE;
    split_wa = parent_idx;
    split_wd = ~split_q;
    case (state)
      S_CLEAR: begin
        prev_we  = 1'b1;
        next_we  = 1'b1;
        split_we = 1'b1;
        prev_wa  = clr_cnt;
        next_wa  = clr_cnt;
        split_wa = clr_cnt[SPLIT_W-1:0];
        split_wd = 1'b0;
      end
      S_UL_LINK: begin
        next_we = (prev_q != NONE_NODE);
        next_wa = prev_q;
        next_wd = next_q;
        prev_we = (next_q != NONE_NODE);
        prev_wa = next_q;
        prev_wd = prev_q;
      end
      S_UL_CLR: begin
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      S_TG_WRITE: begin
        split_we = 1'b1;
      end
      S_PU_W1: begin
        prev_we = 1'b1;
        prev_wd = list_back[lvl];
        next_we = 1'b1;
      end
      S_PU_W2: begin
        next_we = (list_back[lvl] != NONE_NODE);
        next_wa = list_back[lvl];
        next_wd = t;
      end
      default: begin
      end
    endcase
  end

  // RAMs with registered read data
  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (split_we) split_mem[split_wa] <= split_wd;
    prev_q  <= prev_mem[t];
    next_q  <= next_mem[t];
    split_q <= split_mem[parent_idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      heap_base <= '0;
      out_valid <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        list_front[b] <= NONE_NODE;
        list_back[b]  <= NONE_NODE;
      end
      list_front[0] <= '0;
      list_back[0]  <= '0;
    end else begin
      if (cfg_we) heap_base <= cfg_wdata;
      // drop the result once transferred, unless a new one is loaded now
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + NODE_W'(1);
          if (clr_cnt == NONE_NODE) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_data.command;
            need  <= NEED_W'(in_data.request_size) + NEED_W'(HDR_BYTES);
            addr  <= in_data.block_address;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_addr <= '0;
          res_st   <= ST_OK;
          want     <= want_c;
          first    <= 1'b1;
          if (cmd == CMD_ALLOC) begin
            if (need > (NEED_W'(1) << HEAP_LOG2) || !found_c) begin
              res_st <= ST_FAIL;
              state  <= S_FINISH;
            end else begin
              n     <= list_back[sel_c];
              t     <= list_back[sel_c];
              lvl   <= sel_c;
              state <= S_UL_READ;
            end
          end else begin
            if (need > (NEED_W'(1) << HEAP_LOG2) || off_c[31:HEAP_LOG2] != '0) begin
              state <= S_FINISH;
            end else begin
              n     <= fnode_c;
              lvl   <= want_c;
              state <= S_F_LOOP;
            end
          end
        end
        S_UL_READ: begin
          if (cmd == CMD_ALLOC) res_addr <= heap_base + 32'(ofs_c) + 32'(HDR_BYTES);
          state <= S_UL_LINK;
        end
        S_UL_LINK: begin
          if (prev_q == NONE_NODE) list_front[lvl] <= next_q;
          if (next_q == NONE_NODE) list_back[lvl]  <= prev_q;
          state <= S_UL_CLR;
        end
        S_UL_CLR: begin
          if (cmd == CMD_ALLOC) begin
            state <= (n == '0) ? S_A_LOOP : S_TG_READ;
          end else begin
            n     <= n_dec >> 1;
            lvl   <= lvl - LVL_W'(1);
            state <= S_F_LOOP;
          end
        end
        S_TG_READ: begin
          state <= S_TG_WRITE;
        end
        S_TG_WRITE: begin
          if (cmd == CMD_ALLOC) begin
            if (first) begin
              first <= 1'b0;
              state <= S_A_LOOP;
            end else begin
              t     <= n + NODE_W'(1);
              state <= S_PU_W1;
            end
          end else if (~split_q) begin
            t     <= n;
            state <= S_PU_W1;
          end else begin
            t     <= buddy_c;
            state <= S_UL_READ;
          end
        end
        S_A_LOOP: begin
          first <= 1'b0;
          if (lvl < want) begin
            n     <= {n[NODE_W-2:0], 1'b1};
            lvl   <= lvl + LVL_W'(1);
            state <= S_TG_READ;
          end else begin
            state <= S_FINISH;
          end
        end
        S_F_LOOP: begin
          if (n != '0 && lvl != '0) begin
            state <= S_TG_READ;
          end else begin
            t     <= n;
            state <= S_PU_W1;
          end
        end
        S_PU_W1: begin
          state <= S_PU_W2;
        end
        S_PU_W2: begin
          if (list_back[lvl] == NONE_NODE) list_front[lvl] <= t;
          list_back[lvl] <= t;
          state <= (cmd == CMD_ALLOC) ? S_A_LOOP : S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.result_address <= res_addr;
            out_data.status         <= res_st;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
